// ===== hw/rtl/gha_pkg.sv =====
// Shared types and codes for the generational handle allocator.
// Depends on nothing; the top level, the port checks and the testbench import it.
`default_nettype none

package gha_pkg;

    // Fixed field widths of the request and result channels
    localparam int IDX_FIELD_W = 24;
    localparam int SEQ_FIELD_W = 8;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF      = 256;
    localparam int SEQUENCE_BITS_DEF = 8;

    // Operation codes
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_GET   = 3'd2;
    localparam logic [2:0] OP_FIRST = 3'd3;
    localparam logic [2:0] OP_NEXT  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;

    typedef struct packed {
        logic [2:0]             opcode;
        logic [IDX_FIELD_W-1:0] handle_index;
        logic [SEQ_FIELD_W-1:0] handle_sequence;
    } t_req;

    typedef struct packed {
        logic [2:0]             status;
        logic [IDX_FIELD_W-1:0] result_index;
        logic [SEQ_FIELD_W-1:0] result_sequence;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/gha_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator: control sequencer and slot table.
// Depends on gha_pkg and gha_ram.
//
//  channel   | direction | handshake                        | payload
//  ----------+-----------+----------------------------------+---------
//  request   | in        | taken when start=1 and busy=0    | i_req (t_req)
//  result    | out       | o_done high for one cycle        | o_rsp (t_rsp)
//
// Steps: allocate from the free list, free and get (handle in range) read the slot
// table, then finish in S_ALLOC or S_CHECK; allocate and free write the entry back.
// Append, table full, out of range and undefined opcodes finish straight from idle.
// First and next (with a slot in range) scan in S_SCAN, reading one table entry a cycle.
// Reset: synchronous, active low; clears the slot count and the free list.
// The slot table itself is not cleared: only slots below the slot count are read.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int SEQUENCE_BITS = SEQUENCE_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    // Slot index, slot count and table entry geometry
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SB = SEQUENCE_BITS;
    localparam int EW = 1 + SB + IW;       // {free, generation, link}
    localparam int XW = IDX_FIELD_W + 1;   // room for handle_index + 1

    // Control registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_used,  n_used;
    logic [IW-1:0]   r_head,  n_head;
    logic            r_empty, n_empty;
    logic            r_done,  n_done;
    // Request context and result payload
    logic [2:0]             r_op,  n_op;
    logic [IW-1:0]          r_idx, n_idx;
    logic [SEQ_FIELD_W-1:0] r_seq, n_seq;
    t_rsp                   r_rsp, n_rsp;

    // Slot table port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Decoded conditions
    logic          accept;
    logic [XW-1:0] idx_ext;
    logic [XW-1:0] used_ext;
    logic [XW-1:0] next_ext;
    logic          in_range;
    logic          next_in_range;
    logic          can_append;
    logic          rd_free;
    logic [SB-1:0] rd_gen;
    logic [IW-1:0] rd_link;
    logic          seq_match;
    logic [SB-1:0] gen_inc;
    logic [CW-1:0] scan_next;
    logic          scan_more;

    gha_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Handle range checks against the number of slots ever appended
    assign idx_ext       = XW'(i_req.handle_index);
    assign used_ext      = XW'(r_used);
    assign next_ext      = idx_ext + XW'(1);
    assign in_range      = (idx_ext < used_ext);
    assign next_in_range = (next_ext < used_ext);
    assign can_append    = (r_used != CW'(CAPACITY));

    // Split the entry read back from the table
    assign rd_free   = ram_rdata[EW-1];
    assign rd_gen    = ram_rdata[SB+IW-1:IW];
    assign rd_link   = ram_rdata[IW-1:0];
    assign seq_match = (rd_gen == SB'(r_seq));
    assign gen_inc   = rd_gen + SB'(1);

    // Scan pointer: continue while the following slot lies below the slot count
    assign scan_next = CW'(r_idx) + CW'(1);
    assign scan_more = (scan_next < r_used);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.opcode)
                        OP_ALLOC: begin
                            if (!r_empty) begin
                                n_state = S_ALLOC;
                            end
                        end
                        OP_FREE, OP_GET: begin
                            if (in_range) begin
                                n_state = S_CHECK;
                            end
                        end
                        OP_FIRST: begin
                            if (r_used != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_NEXT: begin
                            if (next_in_range) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC, S_CHECK: n_state = S_IDLE;
            S_SCAN: begin
                if (!rd_free || !scan_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, table access and results
    always_comb begin
        n_used    = r_used;
        n_head    = r_head;
        n_empty   = r_empty;
        n_op      = r_op;
        n_idx     = r_idx;
        n_seq     = r_seq;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_req.opcode;
                    n_seq = i_req.handle_sequence;
                    case (i_req.opcode)
                        OP_ALLOC: begin
                            if (!r_empty) begin
                                // Pop the free-list head: read its entry first
                                ram_raddr = r_head;
                                n_idx     = r_head;
                            end else if (can_append) begin
                                // Append a fresh slot at generation zero
                                ram_we    = 1'b1;
                                ram_waddr = IW'(r_used);
                                ram_wdata = '0;
                                n_used    = r_used + CW'(1);
                                n_done    = 1'b1;
                                n_rsp     = '{ST_OK, IDX_FIELD_W'(r_used), '0};
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{ST_FULL, '0, '0};
                            end
                        end
                        OP_FREE, OP_GET: begin
                            if (in_range) begin
                                ram_raddr = IW'(i_req.handle_index);
                                n_idx     = IW'(i_req.handle_index);
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{ST_RANGE, '0, '0};
                            end
                        end
                        OP_FIRST: begin
                            if (r_used != '0) begin
                                ram_raddr = '0;
                                n_idx     = '0;
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{ST_NONE, '0, '0};
                            end
                        end
                        OP_NEXT: begin
                            if (next_in_range) begin
                                ram_raddr = IW'(next_ext);
                                n_idx     = IW'(next_ext);
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{ST_NONE, '0, '0};
                            end
                        end
                        default: begin
                            // Undefined opcodes answer out of range
                            n_done = 1'b1;
                            n_rsp  = '{ST_RANGE, '0, '0};
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // Mark the popped slot allocated, keep generation and link
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {1'b0, rd_gen, rd_link};
                if (rd_link == r_idx) begin
                    n_empty = 1'b1;   // self-link marks the tail
                end else begin
                    n_head = rd_link;
                end
                n_done = 1'b1;
                n_rsp  = '{ST_OK, IDX_FIELD_W'(r_idx), SEQ_FIELD_W'(rd_gen)};
            end
            S_CHECK: begin
                n_done = 1'b1;
                if (rd_free) begin
                    n_rsp = '{ST_NOT_ALLOC, '0, '0};
                end else if (!seq_match) begin
                    n_rsp = '{ST_STALE, '0, '0};
                end else if (r_op == OP_FREE) begin
                    // Push onto the free list and advance the generation
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = {1'b1, gen_inc, (r_empty ? r_idx : r_head)};
                    n_head    = r_idx;
                    n_empty   = 1'b0;
                    n_rsp     = '{ST_OK, IDX_FIELD_W'(r_idx), SEQ_FIELD_W'(gen_inc)};
                end else begin
                    n_rsp = '{ST_OK, IDX_FIELD_W'(r_idx), SEQ_FIELD_W'(rd_gen)};
                end
            end
            S_SCAN: begin
                if (!rd_free) begin
                    n_done = 1'b1;
                    n_rsp  = '{ST_OK, IDX_FIELD_W'(r_idx), SEQ_FIELD_W'(rd_gen)};
                end else if (scan_more) begin
                    // Advance to the next slot, one read per cycle
                    n_idx     = IW'(scan_next);
                    ram_raddr = IW'(scan_next);
                end else begin
                    n_done = 1'b1;
                    n_rsp  = '{ST_NONE, '0, '0};
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_head  <= '0;
            r_empty <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_head  <= n_head;
            r_empty <= n_empty;
            r_done  <= n_done;
        end
    end

    // Request context and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_idx <= n_idx;
        r_seq <= n_seq;
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ===== hw/rtl/gha_checker.sv =====
// Port-level checks for the generational handle allocator, bound to the top level.
// Depends on gha_pkg and generational_handle_allocator.
`default_nettype none

module gha_port_checks
    import gha_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done,
    input wire t_rsp o_rsp
);

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !busy)
        else $error("result or busy after reset");

    // A result follows an accepted request or ongoing work
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result without request");

    // Leaving the busy phase always delivers the result
    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("busy ended without result");

    // Failed requests carry a zero handle
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != ST_OK) |->
            (o_rsp.result_index == '0) && (o_rsp.result_sequence == '0))
        else $error("error result with non-zero handle");

endmodule

bind generational_handle_allocator gha_port_checks u_gha_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire

// ===== tb/gha_checker.sv =====
// Result checker for the generational handle allocator: predicts every accepted request
// and compares each result strobe against the oldest prediction. Depends on gha_pkg.
module gha_checker
    import gha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_req i_req,
    input  wire logic i_done,
    input  wire t_rsp i_rsp,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int GEN_W       = SEQUENCE_BITS_DEF;
    localparam int MAX_PRINTED = 40;

    // Shadow of the slot table and free list
    logic             slot_free [SLOTS];
    logic [GEN_W-1:0] slot_gen  [SLOTS];
    int               slot_link [SLOTS];
    int               used_count;
    int               head_slot;
    logic             list_empty;

    t_rsp             expected_rsp_q[$];

    initial o_fail_count = 0;
    initial o_pending    = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("%0t gha_checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
    endtask

    // Order of the handle check: range, then free slot, then generation.
    function automatic logic [2:0] handle_status(input t_req r);
        int slot;
        slot = int'(r.handle_index);
        if (slot >= used_count) return ST_RANGE;
        if (slot_free[slot]) return ST_NOT_ALLOC;
        if (slot_gen[slot] != r.handle_sequence[GEN_W-1:0]) return ST_STALE;
        return ST_OK;
    endfunction

    function automatic t_rsp apply_request(input t_req r);
        t_rsp rsp;
        int   slot;
        int   scan;
        logic found;
        rsp        = '0;
        rsp.status = ST_OK;
        slot       = int'(r.handle_index);
        case (r.opcode)
            OP_ALLOC: begin
                if (!list_empty) begin
                    slot            = head_slot;
                    slot_free[slot] = 1'b0;
                    // a self-link marks the tail of the free list
                    if (slot_link[slot] == slot) begin
                        list_empty = 1'b1;
                    end else begin
                        head_slot = slot_link[slot];
                    end
                    rsp.result_index    = IDX_FIELD_W'(slot);
                    rsp.result_sequence = SEQ_FIELD_W'(slot_gen[slot]);
                end else if (used_count < SLOTS) begin
                    slot                = used_count;
                    slot_free[slot]     = 1'b0;
                    slot_gen[slot]      = '0;
                    slot_link[slot]     = 0;
                    used_count          = used_count + 1;
                    rsp.result_index    = IDX_FIELD_W'(slot);
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            OP_FREE: begin
                rsp.status = handle_status(r);
                if (rsp.status == ST_OK) begin
                    slot_link[slot]     = list_empty ? slot : head_slot;
                    head_slot           = slot;
                    list_empty          = 1'b0;
                    slot_free[slot]     = 1'b1;
                    slot_gen[slot]      = slot_gen[slot] + 1'b1;
                    rsp.result_index    = IDX_FIELD_W'(slot);
                    rsp.result_sequence = SEQ_FIELD_W'(slot_gen[slot]);
                end
            end
            OP_GET: begin
                rsp.status = handle_status(r);
                if (rsp.status == ST_OK) begin
                    rsp.result_index    = IDX_FIELD_W'(slot);
                    rsp.result_sequence = SEQ_FIELD_W'(slot_gen[slot]);
                end
            end
            OP_FIRST, OP_NEXT: begin
                // next starts one past the given index, without wrapping
                scan  = (r.opcode == OP_FIRST) ? 0 : slot + 1;
                found = 1'b0;
                while (!found && scan < used_count) begin
                    if (!slot_free[scan]) begin
                        found = 1'b1;
                    end else begin
                        scan++;
                    end
                end
                if (found) begin
                    rsp.result_index    = IDX_FIELD_W'(scan);
                    rsp.result_sequence = SEQ_FIELD_W'(slot_gen[scan]);
                end else begin
                    rsp.status = ST_NONE;
                end
            end
            default: begin
                rsp.status = ST_RANGE;
            end
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_free[i] = 1'b0;
                slot_gen[i]  = '0;
                slot_link[i] = 0;
            end
            used_count = 0;
            head_slot  = 0;
            list_empty = 1'b1;
            expected_rsp_q.delete();
        end else begin
            // retire the result first: it belongs to an earlier request
            if (i_done) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", 64'(i_rsp), '0);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.status != want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                    if (i_rsp.result_index != want.result_index)
                        report_mismatch("result_index", 64'(i_rsp.result_index),
                                        64'(want.result_index));
                    if (i_rsp.result_sequence != want.result_sequence)
                        report_mismatch("result_sequence", 64'(i_rsp.result_sequence),
                                        64'(want.result_sequence));
                end
            end
            if (i_start && !i_busy) begin
                expected_rsp_q.push_back(apply_request(i_req));
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the handle allocator testbench: directed and random request streams with
// random sender gaps, a watchdog and the verdict. Depends on gha_pkg and gha_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // several times the longest scan
    localparam int SETTLE_CYCLES  = CAPACITY_DEF + 44;
    localparam int RETIRED_DEPTH  = 16;

    localparam logic [2:0]             OP_UNDEF_LO = 3'd5;
    localparam logic [2:0]             OP_UNDEF_HI = 3'd7;
    localparam logic [IDX_FIELD_W-1:0] IDX_MAX     = '1;
    localparam logic [SEQ_FIELD_W-1:0] SEQ_MAX     = '1;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] idx;
        logic [SEQ_FIELD_W-1:0] gen;
    } t_handle;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;

    // Sender gap rate in percent; changed between phases
    int      idle_pct = 20;
    int      stalled_cycles = 0;

    // Requests in flight, and handles learnt from the results. These steer the
    // stimulus only; the checker decides what is right.
    t_req    issued_q[$];
    t_handle live_pool[$];
    t_handle retired_pool[$];
    t_handle last_alloc;
    logic    last_alloc_ok = 1'b0;

    generational_handle_allocator #(
        .CAPACITY      (CAPACITY_DEF),
        .SEQUENCE_BITS (SEQUENCE_BITS_DEF)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    gha_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run when neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("[generational_handle_allocator] ERROR");
            $finish;
        end
    end

    // Harvest handles from the results so that later requests can name live,
    // freed and stale handles. The pool update and the pop happen together,
    // so an empty issued_q means the pool is up to date.
    always @(posedge i_clk) begin : harvest
        t_req    req_done;
        t_handle h;
        int      pos;
        if (i_rst_n && o_done && issued_q.size() != 0) begin
            req_done = issued_q[0];
            h.idx    = o_rsp.result_index;
            h.gen    = o_rsp.result_sequence;
            if (req_done.opcode == OP_ALLOC) begin
                last_alloc_ok = (o_rsp.status == ST_OK);
                if (o_rsp.status == ST_OK) begin
                    live_pool.push_back(h);
                    last_alloc = h;
                end
            end
            if (req_done.opcode == OP_FREE && o_rsp.status == ST_OK) begin
                pos = -1;
                foreach (live_pool[i]) begin
                    if (live_pool[i].idx == h.idx) pos = i;
                end
                if (pos >= 0) live_pool.delete(pos);
                // keep the generation the handle had before the free
                h.gen = h.gen - 1'b1;
                retired_pool.push_back(h);
                if (retired_pool.size() > RETIRED_DEPTH) void'(retired_pool.pop_front());
            end
            void'(issued_q.pop_front());
        end
    end

    // Offer one request: hold start low for a random gap, then raise it and
    // hold it until the block takes the request. start stays high on return,
    // so a following request goes out back to back.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        issued_q.push_back(r);
    endtask

    // Drop start and wait until every result in flight has come back.
    task automatic wait_results();
        start <= 1'b0;
        do @(posedge i_clk); while (issued_q.size() != 0);
    endtask

    function automatic t_req make_req(input logic [2:0] op, input logic [IDX_FIELD_W-1:0] idx,
                                      input logic [SEQ_FIELD_W-1:0] seq);
        t_req r;
        r.opcode          = op;
        r.handle_index    = idx;
        r.handle_sequence = seq;
        return r;
    endfunction

    // Mostly live handles; the rest are retired, wrong-generation, near-range
    // and wild handles.
    function automatic t_handle pick_handle();
        t_handle h;
        int      k;
        h.idx = IDX_FIELD_W'($urandom_range(300));
        h.gen = SEQ_FIELD_W'($urandom());
        k     = $urandom_range(9);
        if (k <= 5 && live_pool.size() != 0) begin
            h = live_pool[$urandom_range(live_pool.size() - 1)];
        end else if (k == 6 && retired_pool.size() != 0) begin
            h = retired_pool[$urandom_range(retired_pool.size() - 1)];
        end else if (k == 7 && live_pool.size() != 0) begin
            h     = live_pool[$urandom_range(live_pool.size() - 1)];
            h.gen = h.gen ^ SEQ_FIELD_W'($urandom_range(255, 1));
        end else if (k == 9) begin
            h.idx = IDX_FIELD_W'($urandom());
        end
        return h;
    endfunction

    function automatic t_req random_request(input int w_alloc, input int w_free);
        t_req    r;
        t_handle h;
        int      roll;
        // fields an operation ignores still carry random bits
        r = make_req(OP_ALLOC, IDX_FIELD_W'($urandom()), SEQ_FIELD_W'($urandom()));
        h = pick_handle();
        roll = $urandom_range(99);
        if (roll < w_alloc) begin
            r.opcode = OP_ALLOC;
        end else if (roll < w_alloc + w_free) begin
            r = make_req(OP_FREE, h.idx, h.gen);
        end else begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                r = make_req(OP_GET, h.idx, h.gen);
            end else if (roll < 75) begin
                r.opcode = OP_NEXT;
                roll     = $urandom_range(9);
                if (roll <= 6) begin
                    r.handle_index = h.idx;
                end else if (roll == 7) begin
                    r.handle_index = IDX_MAX;
                end
            end else if (roll < 88) begin
                r.opcode = OP_FIRST;
            end else begin
                r.opcode = 3'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
            end
        end
        return r;
    endfunction

    task automatic run_mixed(input int count, input int w_alloc, input int w_free);
        repeat (count) send_request(random_request(w_alloc, w_free));
    endtask

    // Allocate and free the same slot over and over: the LIFO free list hands
    // the slot straight back, so its generation runs through the wrap.
    task automatic cycle_one_slot(input int rounds);
        wait_results();
        if (live_pool.size() != 0) begin
            send_request(make_req(OP_FREE, live_pool[0].idx, live_pool[0].gen));
        end
        repeat (rounds) begin
            send_request(make_req(OP_ALLOC, IDX_FIELD_W'($urandom()), SEQ_FIELD_W'($urandom())));
            wait_results();
            if (last_alloc_ok) begin
                send_request(make_req(OP_FREE, last_alloc.idx, last_alloc.gen));
            end
        end
    endtask

    // Short directed walk from reset through the corner cases.
    task automatic run_directed();
        send_request(make_req(OP_FIRST, '0, '0));          // empty table: none found
        send_request(make_req(OP_NEXT, '0, '0));
        send_request(make_req(OP_GET, '0, '0));            // out of range
        send_request(make_req(OP_FREE, IDX_MAX, SEQ_MAX));
        repeat (3) send_request(make_req(OP_ALLOC, '0, '0)); // append slots 0, 1, 2
        send_request(make_req(OP_GET, 24'd1, 8'd0));
        send_request(make_req(OP_GET, 24'd1, SEQ_MAX));    // stale generation
        send_request(make_req(OP_FREE, 24'd1, 8'd0));      // onto an empty list: self-link
        send_request(make_req(OP_GET, 24'd1, 8'd1));       // slot on the free list
        send_request(make_req(OP_FREE, 24'd1, 8'd1));      // double free
        send_request(make_req(OP_FREE, 24'd2, 8'd0));
        send_request(make_req(OP_FIRST, IDX_MAX, SEQ_MAX));
        send_request(make_req(OP_NEXT, '0, '0));           // skips both free slots
        send_request(make_req(OP_ALLOC, IDX_MAX, SEQ_MAX)); // pops slot 2
        send_request(make_req(OP_ALLOC, '0, '0));          // pops the tail, list empties
        send_request(make_req(OP_ALLOC, '0, '0));          // appends slot 3
        send_request(make_req(OP_NEXT, IDX_MAX, SEQ_MAX)); // start beyond the table
        send_request(make_req(OP_NEXT, 24'd1, '0));
        send_request(make_req(OP_GET, 24'd3, SEQ_MAX));
        for (int op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++) begin
            send_request(make_req(3'(op), IDX_MAX, SEQ_MAX));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // light sender gaps; fill the table until it reports full
        idle_pct = 20;
        run_directed();
        run_mixed(420, 70, 6);

        // heavy sender gaps; wrap one generation, then drain the table
        idle_pct = 73;
        cycle_one_slot(260);
        run_mixed(100, 20, 40);

        // back to back
        idle_pct = 0;
        run_mixed(280, 30, 25);

        wait_results();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[generational_handle_allocator] OK");
        end else begin
            $display("[generational_handle_allocator] ERROR");
        end
        $finish;
    end

endmodule
